[rtl/qubit_state_vector_gate_engine_macros.svh]
// Assertion macros used by the checker file of the gate engine.
`ifndef QUBIT_STATE_VECTOR_GATE_ENGINE_MACROS_SVH
`define QUBIT_STATE_VECTOR_GATE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define QSVE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define QSVE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/qsve_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package qsve_pkg;

    localparam int MAX_QUBITS = 10;

    localparam int NQ_W   = 4;
    localparam int IDX_W  = 10;
    localparam int MODE_W = 2;
    localparam int KIND_W = 3;

    localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GATE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CNOT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

    localparam logic [KIND_W-1:0] GATE_H = 3'd0;
    localparam logic [KIND_W-1:0] GATE_X = 3'd1;
    localparam logic [KIND_W-1:0] GATE_Y = 3'd2;
    localparam logic [KIND_W-1:0] GATE_Z = 3'd3;
    localparam logic [KIND_W-1:0] GATE_I = 3'd4;

    localparam logic signed [30:0] INV_ROOT2_Q30 = 31'sd759250125;
    localparam int                 INV_SHIFT     = 30;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_CHK   = 8'b0000_0100,
        S_RD    = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_WLO   = 8'b0010_0000,
        S_WHI   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic rd_pair;
        logic rd_amp;
        logic mul;
        logic wr_lo;
        logic wr_hi;
        logic pair_next;
        logic res_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic clr_last;
        logic pair_last;
        logic bad;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

[rtl/qsve_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface qsve_cmd_if import qsve_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [KIND_W-1:0] gate_kind;
    logic [NQ_W-1:0]   target_qubit;
    logic [NQ_W-1:0]   control_qubit;
    logic [IDX_W-1:0]  amp_index;
    modport source (output valid, mode, gate_kind, target_qubit, control_qubit, amp_index,
                    input ready);
    modport sink (input valid, mode, gate_kind, target_qubit, control_qubit, amp_index,
                  output ready);
endinterface

interface qsve_res_if #(parameter int AMP_W = 18) ();
    logic                    valid;
    logic                    ready;
    logic signed [AMP_W-1:0] amp_real;
    logic signed [AMP_W-1:0] amp_imag;
    logic                    status;
    modport source (output valid, amp_real, amp_imag, status, input ready);
    modport sink (input valid, amp_real, amp_imag, status, output ready);
endinterface

interface qsve_cfg_if import qsve_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [NQ_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/qubit_state_vector_gate_engine.sv]
// Gate or CNOT: each amplitude pair is read, multiplied, then written low and high through the
// single write port of the amplitude store.
// One command is in flight at a time; a result may wait while the next command is taken.
// After i_rst_n the store is cleared to the all-zero basis state in one pass, during which
// no command is taken; configuration writes are taken at all times.
`timescale 1ns / 1ps
`default_nettype none
module qubit_state_vector_gate_engine import qsve_pkg::*; #(
    parameter int AMP_FRAC_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    qsve_cmd_if.sink   i_cmd,
    qsve_res_if.source o_res,
    qsve_cfg_if.sink   i_cfg
);

    t_ctl_cmd ctl_cmd;
    t_dp_sts  dp_sts;

    assign i_cfg.ready = 1'b1;

    qsve_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .i_mode     (i_cmd.mode),
        .o_in_ready (i_cmd.ready),
        .i_sts      (dp_sts),
        .o_cmd      (ctl_cmd)
    );

    qsve_dp #(
        .AMP_FRAC_BITS (AMP_FRAC_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctl_cmd),
        .o_sts           (dp_sts),
        .i_mode          (i_cmd.mode),
        .i_gate_kind     (i_cmd.gate_kind),
        .i_target_qubit  (i_cmd.target_qubit),
        .i_control_qubit (i_cmd.control_qubit),
        .i_amp_index     (i_cmd.amp_index),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_data      (i_cfg.data),
        .i_out_ready     (o_res.ready),
        .o_out_valid     (o_res.valid),
        .o_amp_real      (o_res.amp_real),
        .o_amp_imag      (o_res.amp_imag),
        .o_status        (o_res.status)
    );

endmodule
`default_nettype wire

[rtl/qsve_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module qsve_ctrl import qsve_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic [MODE_W-1:0] i_mode,
    output logic                   o_in_ready,
    input  wire t_dp_sts           i_sts,
    output t_ctl_cmd               o_cmd
);

    t_state            r_state, n_state;
    logic [MODE_W-1:0] r_mode, n_mode;
    logic              r_clr_reply, n_clr_reply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_mode      <= MODE_RESET;
            r_clr_reply <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_clr_reply <= n_clr_reply;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_clr_reply = r_clr_reply;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_clr_reply ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_mode     = i_mode;
                    if (i_mode == MODE_RESET) begin
                        n_state     = S_CLEAR;
                        n_clr_reply = 1'b1;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (r_mode == MODE_READ) begin
                    o_cmd.rd_amp = 1'b1;
                    n_state      = S_DONE;
                end else if (i_sts.bad) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_pair = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_WLO;
            end
            S_WLO: begin
                o_cmd.wr_lo = 1'b1;
                n_state     = S_WHI;
            end
            S_WHI: begin
                o_cmd.wr_hi     = 1'b1;
                o_cmd.pair_next = 1'b1;
                n_state         = i_sts.pair_last ? S_DONE : S_RD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_clr_reply    = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/qsve_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module qsve_dp import qsve_pkg::*; #(
    parameter int AMP_FRAC_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire t_ctl_cmd                            i_cmd,
    output t_dp_sts                                  o_sts,
    input  wire logic [MODE_W-1:0]                   i_mode,
    input  wire logic [KIND_W-1:0]                   i_gate_kind,
    input  wire logic [NQ_W-1:0]                     i_target_qubit,
    input  wire logic [NQ_W-1:0]                     i_control_qubit,
    input  wire logic [IDX_W-1:0]                    i_amp_index,
    input  wire logic                                i_cfg_valid,
    input  wire logic [NQ_W-1:0]                     i_cfg_data,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic signed [AMP_FRAC_BITS+1:0]          o_amp_real,
    output logic signed [AMP_FRAC_BITS+1:0]          o_amp_imag,
    output logic                                     o_status
);

    localparam int AW    = MAX_QUBITS;
    localparam int DEPTH = 1 << AW;
    localparam int AMP_W = AMP_FRAC_BITS + 2;
    localparam int SW    = AMP_W + 1;
    localparam int PW    = SW + 31;
    localparam int KW    = (MAX_QUBITS > 1) ? MAX_QUBITS - 1 : 1;
    localparam logic signed [AMP_W-1:0] AMP_MAX = {1'b0, {(AMP_W-1){1'b1}}};
    localparam logic signed [AMP_W-1:0] AMP_MIN = {1'b1, {(AMP_W-1){1'b0}}};
    localparam logic signed [AMP_W-1:0] AMP_ONE = AMP_W'(1) << AMP_FRAC_BITS;

    logic [2*AMP_W-1:0] mem [DEPTH];
    logic [2*AMP_W-1:0] r_rda, r_rdb;

    logic [NQ_W-1:0]   r_num_qubits;
    logic [MODE_W-1:0] r_mode;
    logic [KIND_W-1:0] r_kind;
    logic [NQ_W-1:0]   r_tq, r_cq;
    logic [IDX_W-1:0]  r_idx;
    logic [AW-1:0]     r_clr_addr;
    logic [KW-1:0]     r_k;

    logic signed [PW-1:0] r_p_sr, r_p_si, r_p_dr, r_p_di;

    logic                    r_out_valid;
    logic signed [AMP_W-1:0] r_out_re, r_out_im;
    logic                    r_out_status;

    logic                    n_ok, bad;
    logic [NQ_W-1:0]         pos_t, pos_c, pos_last;
    logic [AW-1:0]           kk, low_mask, lo, hi, cmask;
    logic [AW-1:0]           waddr, raddr_a;
    logic                    we;
    logic [2*AMP_W-1:0]      wdata;
    logic [KIND_W-1:0]       eff_kind;
    logic signed [AMP_W-1:0] ar, ai, br, bi;
    logic signed [SW-1:0]    s_r, s_i, d_r, d_i;
    logic signed [AMP_W-1:0] lo_re, lo_im, hi_re, hi_im;

    function automatic logic signed [AMP_W-1:0] sat_neg(input logic signed [AMP_W-1:0] v);
        return (v == AMP_MIN) ? AMP_MAX : -v;
    endfunction

    function automatic logic signed [AMP_W-1:0] rnd_sat(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        t = (p + (PW'(1) <<< (INV_SHIFT - 1))) >>> INV_SHIFT;
        if (t > PW'(AMP_MAX)) begin
            return AMP_MAX;
        end else if (t < PW'(AMP_MIN)) begin
            return AMP_MIN;
        end
        return AMP_W'(t);
    endfunction

    // Validation of the held item against the qubit count.
    always_comb begin
        n_ok = (r_num_qubits != '0) && ({1'b0, r_num_qubits} <= 5'(MAX_QUBITS));
        case (r_mode)
            MODE_GATE: bad = !n_ok || (r_tq >= r_num_qubits);
            MODE_CNOT: bad = !n_ok || (r_tq >= r_num_qubits) || (r_cq >= r_num_qubits)
                             || (r_tq == r_cq);
            MODE_READ: bad = !n_ok || ({7'b0, r_idx} >= (17'(1) << r_num_qubits));
            default:   bad = 1'b0;
        endcase
    end

    // Pair addresses: a zero inserted at the target bit of the pair counter.
    always_comb begin
        pos_t    = r_num_qubits - NQ_W'(1) - r_tq;
        pos_c    = r_num_qubits - NQ_W'(1) - r_cq;
        pos_last = r_num_qubits - NQ_W'(1);
        kk       = AW'(r_k);
        low_mask = (AW'(1) << pos_t) - AW'(1);
        lo       = ((kk & ~low_mask) << 1) | (kk & low_mask);
        hi       = lo | (AW'(1) << pos_t);
        cmask    = AW'(1) << pos_c;
    end

    assign o_sts.clr_last  = (r_clr_addr == '1);
    assign o_sts.pair_last = (kk == ((AW'(1) << pos_last) - AW'(1)));
    assign o_sts.bad       = bad;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_qubits <= NQ_W'(1);
            r_clr_addr   <= '0;
            r_k          <= '0;
            r_mode       <= MODE_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_num_qubits <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.load) begin
                r_mode <= i_mode;
                r_k    <= '0;
            end else if (i_cmd.pair_next) begin
                r_k <= r_k + KW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_gate_kind;
            r_tq   <= i_target_qubit;
            r_cq   <= i_control_qubit;
            r_idx  <= i_amp_index;
        end
    end

    // Amplitude store: one write port and two read ports.
    always_comb begin
        we      = i_cmd.clr_step || i_cmd.wr_lo || i_cmd.wr_hi;
        raddr_a = i_cmd.rd_amp ? AW'(r_idx) : lo;
        if (i_cmd.clr_step) begin
            waddr = r_clr_addr;
            wdata = (r_clr_addr == '0) ? {AMP_ONE, {AMP_W{1'b0}}} : '0;
        end else if (i_cmd.wr_lo) begin
            waddr = lo;
            wdata = {lo_re, lo_im};
        end else begin
            waddr = hi;
            wdata = {hi_re, hi_im};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_cmd.rd_pair || i_cmd.rd_amp) begin
            r_rda <= mem[raddr_a];
            r_rdb <= mem[hi];
        end
    end

    always_comb begin
        ar  = r_rda[2*AMP_W-1:AMP_W];
        ai  = r_rda[AMP_W-1:0];
        br  = r_rdb[2*AMP_W-1:AMP_W];
        bi  = r_rdb[AMP_W-1:0];
        s_r = SW'(ar) + SW'(br);
        s_i = SW'(ai) + SW'(bi);
        d_r = SW'(ar) - SW'(br);
        d_i = SW'(ai) - SW'(bi);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p_sr <= PW'(s_r) * PW'(INV_ROOT2_Q30);
            r_p_si <= PW'(s_i) * PW'(INV_ROOT2_Q30);
            r_p_dr <= PW'(d_r) * PW'(INV_ROOT2_Q30);
            r_p_di <= PW'(d_i) * PW'(INV_ROOT2_Q30);
        end
    end

    always_comb begin
        if (r_mode == MODE_CNOT) begin
            eff_kind = ((lo & cmask) != '0) ? GATE_X : GATE_I;
        end else begin
            eff_kind = r_kind;
        end
        lo_re = ar;
        lo_im = ai;
        hi_re = br;
        hi_im = bi;
        case (eff_kind)
            GATE_H: begin
                lo_re = rnd_sat(r_p_sr);
                lo_im = rnd_sat(r_p_si);
                hi_re = rnd_sat(r_p_dr);
                hi_im = rnd_sat(r_p_di);
            end
            GATE_X: begin
                lo_re = br;
                lo_im = bi;
                hi_re = ar;
                hi_im = ai;
            end
            GATE_Y: begin
                lo_re = bi;
                lo_im = sat_neg(br);
                hi_re = sat_neg(ai);
                hi_im = ar;
            end
            GATE_Z: begin
                hi_re = sat_neg(br);
                hi_im = sat_neg(bi);
            end
            default: begin
                lo_re = ar;
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_out_status <= bad;
            if ((r_mode == MODE_READ) && !bad) begin
                r_out_re <= ar;
                r_out_im <= ai;
            end else begin
                r_out_re <= '0;
                r_out_im <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_amp_real  = r_out_re;
    assign o_amp_imag  = r_out_im;
    assign o_status    = r_out_status;

endmodule
`default_nettype wire

[rtl/qsve_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "qubit_state_vector_gate_engine_macros.svh"
module qsve_checker #(
    parameter int AMP_FRAC_BITS = 16
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [AMP_FRAC_BITS+1:0]     i_amp_real,
    input wire logic [AMP_FRAC_BITS+1:0]     i_amp_imag,
    input wire logic                         i_status
);

    `QSVE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped before transfer")
    `QSVE_ASSERT_IMP(a_bad_zero, i_clk, i_rst_n, i_out_valid && i_status, (i_amp_real == '0) && (i_amp_imag == '0), "failed command carries a non-zero amplitude")
    `QSVE_ASSERT_IMP(a_clear_busy, i_clk, i_rst_n, !$past(i_rst_n), !i_in_ready, "command taken during the clearing pass")
    `QSVE_ASSERT_NXT(a_one_cmd, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "second command taken while one is in progress")

endmodule

bind qubit_state_vector_gate_engine qsve_checker #(
    .AMP_FRAC_BITS (AMP_FRAC_BITS)
) u_qsve_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_amp_real  (o_res.amp_real),
    .i_amp_imag  (o_res.amp_imag),
    .i_status    (o_res.status)
);
`default_nettype wire
